// ----- hw/rtl/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int LEN_W = 5;
    // ages run up to window length minus one, window length at most 31 from the 5-bit length
    localparam int AGE_W = 8;

    typedef struct packed {
        logic                       valid;
        logic [AGE_W-1:0]           age;
        logic signed [SAMPLE_W-1:0] value;
    } cell_t;

    typedef struct packed {
        logic                       evict;
        logic [AGE_W-1:0]           age_last;
        logic signed [SAMPLE_W-1:0] sample;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/swm_cell.sv -----
`default_nettype none

module swm_cell
    import swm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire logic  flush,
    input  wire cmd_t  cmd,
    input  wire cell_t up_raw,
    input  wire cell_t low_post,
    input  wire logic  low_h,
    input  wire logic  low_p,
    output cell_t      raw,
    output cell_t      post,
    output logic       h,
    output logic       p
);

    logic                       valid_reg;
    logic [AGE_W-1:0]           age_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    cell_t                      next;
    logic                       del;

    always_comb
    begin
        raw.valid = valid_reg & ~flush;
        raw.age   = age_reg;
        raw.value = value_reg;
        del  = cmd.evict & raw.valid & (age_reg == cmd.age_last);
        // an entry removed here or below pulls the upper neighbor down
        p    = low_p | del;
        post = p ? up_raw : raw;
        // new sample lands at or below this slot
        h    = ~post.valid | (post.value > cmd.sample);
        if (h)
        begin
            if (low_h)
            begin
                next.valid = low_post.valid;
                next.age   = low_post.age + AGE_W'(1);
                next.value = low_post.value;
            end
            else
            begin
                next.valid = 1'b1;
                next.age   = '0;
                next.value = cmd.sample;
            end
        end
        else
        begin
            next.valid = post.valid;
            next.age   = post.age + AGE_W'(1);
            next.value = post.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            age_reg   <= next.age;
            value_reg <= next.value;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_median_core.sv -----
// result: an accepted sample that gives a word leaves it pending until the output register is free
// throughput: one sample per cycle while the output side keeps taking words
// the sorted cell row absorbs insert and evict in the accept cycle, the median
// tap is added into the output register when the pending word moves out
// reset: window empty, window_len = 3, no result pending
`default_nettype none

module sliding_window_median_core
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // sample
    input  wire logic        s_tlast,   // end_of_sequence
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // median_twice, zero fill
    output logic             m_tuser,   // partial
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [LEN_W-1:0] len_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             flush_reg;
    logic             pend_reg;
    logic             pend_partial_reg;
    logic [IDX_W-1:0] ia_reg;
    logic [IDX_W-1:0] ib_reg;
    logic             out_valid_reg;
    logic signed [MEDIAN_W-1:0] out_data_reg;
    logic             out_partial_reg;

    logic [CNT_W-1:0] len_eff;
    logic [CNT_W-1:0] fill_eff;
    logic [CNT_W-1:0] fill_new;
    logic             full_before;
    logic             accept;
    logic             move;
    logic             emit;
    cmd_t             cmd;

    cell_t raw_c   [WINDOW_MAX+1];
    cell_t post_c  [WINDOW_MAX+1];
    logic  h_c     [WINDOW_MAX+1];
    logic  p_c     [WINDOW_MAX+1];
    logic signed [SAMPLE_W-1:0] vals [WINDOW_MAX];

    always_comb
    begin
        if (len_reg == '0)
            len_eff = CNT_W'(1);
        else if (32'(len_reg) > 32'(WINDOW_MAX))
            len_eff = CNT_W'(WINDOW_MAX);
        else
            len_eff = CNT_W'(len_reg);
        fill_eff    = flush_reg ? '0 : fill_reg;
        full_before = fill_eff >= len_eff;
        fill_new    = full_before ? fill_eff : fill_eff + CNT_W'(1);
        emit        = (fill_new == len_eff) | s_tlast;
        move        = pend_reg & (~out_valid_reg | m_tready);
        s_tready    = ~pend_reg | move;
        accept      = s_tvalid & s_tready;
        cmd.evict    = full_before;
        cmd.age_last = AGE_W'(len_eff - CNT_W'(1));
        cmd.sample   = s_tdata;
    end

    // boundaries of the row
    assign raw_c[WINDOW_MAX] = '0;
    assign post_c[0] = '0;
    assign h_c[0]    = 1'b0;
    assign p_c[0]    = 1'b0;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        cell_t raw_i;
        cell_t post_i;
        logic  h_i;
        logic  p_i;

        swm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (accept),
            .flush    (flush_reg),
            .cmd      (cmd),
            .up_raw   (raw_c[i+1]),
            .low_post (post_c[i]),
            .low_h    (h_c[i]),
            .low_p    (p_c[i]),
            .raw      (raw_i),
            .post     (post_i),
            .h        (h_i),
            .p        (p_i)
        );

        assign raw_c[i]    = raw_i;
        assign post_c[i+1] = post_i;
        assign h_c[i+1]    = h_i;
        assign p_c[i+1]    = p_i;
        assign vals[i]     = raw_i.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(3);
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg   <= cfg_wdata;
                fill_reg  <= '0;
                flush_reg <= 1'b1;
            end
            else if (accept)
            begin
                fill_reg  <= fill_new;
                flush_reg <= s_tlast;
            end
            if (accept)
                pend_reg <= emit;
            else if (move)
                pend_reg <= 1'b0;
            if (move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            // middle pair of the sorted row, same slot twice for an odd count
            ia_reg           <= IDX_W'((fill_new - CNT_W'(1)) >> 1);
            ib_reg           <= IDX_W'(fill_new >> 1);
            pend_partial_reg <= (fill_new != len_eff);
        end
        if (move)
        begin
            out_data_reg    <= MEDIAN_W'(vals[ia_reg]) + MEDIAN_W'(vals[ib_reg]);
            out_partial_reg <= pend_partial_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_data_reg};
    assign m_tuser  = out_partial_reg;

endmodule

`default_nettype wire

// ----- bench/tb_sliding_window_median_core.sv -----
`timescale 1ns / 1ps

module tb_sliding_window_median_core;
    import swm_pkg::*;

    localparam int WIN_DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;
    localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [MEDIAN_W-1:0] median_twice;
        logic                partial;
    } median_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // sample
    logic        s_tlast = 1'b0;    // end_of_sequence
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // median_twice, zero fill
    logic        m_tuser;           // partial
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    // window model
    logic signed [SAMPLE_W-1:0] win_store [WIN_DEPTH];
    int unsigned                fill_count;
    int unsigned                oldest_ptr;
    logic [LEN_W-1:0]           win_len;

    median_word_t pending_medians [$];
    bit           quiet = 1'b0;
    int unsigned  cycles = 0;
    int unsigned  samples_sent = 0;
    int unsigned  words_checked = 0;
    int unsigned  partial_words = 0;
    int unsigned  len_writes = 0;
    int unsigned  mismatches = 0;

    sliding_window_median_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_medians.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(99) >= 13);
    end

    function automatic int unsigned active_len();
        if (win_len == 0)
            return 1;
        if (win_len > WIN_DEPTH)
            return WIN_DEPTH;
        return 32'(win_len);
    endfunction

    function automatic logic [MEDIAN_W-1:0] sorted_mid_sum(input int unsigned count);
        longint sorted [WIN_DEPTH];
        longint v;
        int     j;
        longint sum;
        for (int i = 0; i < count; i++)
            sorted[i] = longint'(win_store[i]);
        for (int i = 1; i < count; i++)
        begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (count % 2 == 1)
            sum = 2 * sorted[count/2];
        else
            sum = sorted[count/2 - 1] + sorted[count/2];
        return sum[MEDIAN_W-1:0];
    endfunction

    task automatic predict_median(input logic [31:0] sample, input logic last);
        int unsigned  len;
        median_word_t word;
        len = active_len();
        if (fill_count < len)
        begin
            win_store[fill_count] = sample;
            fill_count++;
        end
        else
        begin
            if (oldest_ptr >= len)
                oldest_ptr = 0;
            win_store[oldest_ptr] = sample;
            oldest_ptr++;
            if (oldest_ptr >= len)
                oldest_ptr = 0;
        end
        if (fill_count >= len)
        begin
            word.median_twice = sorted_mid_sum(len);
            word.partial = 1'b0;
            pending_medians.insert(pending_medians.size(), word);
        end
        else if (last)
        begin
            word.median_twice = sorted_mid_sum(fill_count);
            word.partial = 1'b1;
            pending_medians.insert(pending_medians.size(), word);
        end
        if (last)
        begin
            fill_count = 0;
            oldest_ptr = 0;
        end
    endtask

    always @(posedge clk)
    begin
        median_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_medians.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected word: median_twice=%h partial=%b",
                             m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_medians.pop_front();
                words_checked++;
                if (want.partial)
                    partial_words++;
                if (m_tdata !== {7'd0, want.median_twice} || m_tuser !== want.partial)
                begin
                    if (mismatches < 10)
                        $display("word %0d: median_twice exp %h got %h, partial exp %b got %b",
                                 words_checked, {7'd0, want.median_twice}, m_tdata,
                                 want.partial, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_sample(input logic [31:0] sample, input logic last);
        if (!quiet)
        begin
            while ($urandom_range(99) < 13)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_median(sample, last);
        samples_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge clk);
        // a sample that gives no word may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window_len(input logic [4:0] len_val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= len_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_len = len_val;
        fill_count = 0;
        oldest_ptr = 0;
        len_writes++;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return 32'hFFFF_FFFF;
            3, 4: return $urandom_range(6) - 3;   // small values give many ties
            default: return $urandom;
        endcase
    endfunction

    // reset length 3, odd window, ending on a partly refilled window
    task automatic test_default_len();
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0, 1'b0);
        send_sample(32'd5, 1'b1);
        send_sample(32'd7, 1'b1);
    endtask

    // even window at the extremes of the sum, window filling on the last word
    task automatic test_even_extremes();
        set_window_len(5'd2);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_zero_len();
        set_window_len(5'd0);
        send_sample(32'h1234_5678, 1'b0);
        send_sample(32'hFEDC_BA98, 1'b1);
    endtask

    // length above the store depth acts as full depth; short run gives partial
    task automatic test_oversize_len();
        set_window_len(5'd31);
        send_sample(32'd10, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(32'd4, 1'b1);
    endtask

    // a write with samples in the window throws them away
    task automatic test_write_mid_stream();
        set_window_len(5'd16);
        send_sample(32'd100, 1'b0);
        send_sample(32'd200, 1'b0);
        set_window_len(5'd1);
        send_sample(32'd9, 1'b0);
        send_sample(32'hFFFF_FFF7, 1'b0);
    endtask

    task automatic test_random_streams();
        int unsigned start_count;
        int unsigned phase;
        int unsigned run_len;
        int unsigned len;
        logic [4:0]  len_val;
        start_count = samples_sent;
        phase = 0;
        while (samples_sent - start_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(7))
                0: len_val = 5'd0;
                1: len_val = 5'd1;
                2: len_val = 5'd16;
                3: len_val = 5'd31;
                default: len_val = 5'($urandom_range(31));
            endcase
            set_window_len(len_val);
            quiet = (phase >= 6 && phase < 9);
            len = active_len();
            for (int n = 0; n < 60; n++)
            begin
                // mostly runs past the fill point, some short ones end partial
                if ($urandom_range(3) == 0)
                    run_len = $urandom_range(1, len);
                else
                    run_len = $urandom_range(len, 3 * len + 8);
                for (int k = 1; k <= run_len; k++)
                begin
                    send_sample(pick_sample(), k == run_len && $urandom_range(9) != 0);
                    n++;
                end
            end
            phase++;
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        win_len = 5'd3;
        fill_count = 0;
        oldest_ptr = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_len();
        test_even_extremes();
        test_zero_len();
        test_oversize_len();
        test_write_mid_stream();
        test_random_streams();

        drain_results();
        repeat (10) @(posedge clk);
        $display("sent %0d samples over %0d window length settings (0 to 31)",
                 samples_sent, len_writes + 1);
        $display("checked %0d median words, %0d of them from partial windows, %0d mismatches",
                 words_checked, partial_words, mismatches);
        if (mismatches == 0 && pending_medians.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_median_core.sv
bench/tb_sliding_window_median_core.sv
